FILE: design/lnsil_pkg.sv
package lnsil_pkg;

    // Command codes carried on the mode field
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Field widths fixed by the interface
    localparam int unsigned ENERGY_W = 32;
    localparam int unsigned TAG_PORT_W = 32;
    localparam int unsigned SLOT_W = 4;

    typedef logic signed [ENERGY_W-1:0] energy_t;

    // Value held by an empty slot
    localparam energy_t ENERGY_MAX = 32'sh7FFF_FFFF;

endpackage

FILE: design/lnsil_ram.sv
module lnsil_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/lowest_n_sorted_insert_list_unit.sv
// Lowest-N sorted list of energies with tags.
// Input: a command beat is taken on a clock edge where start is high and busy
// is low; mode selects insert (energy, tag), read next entry, or clear.
// Output: exactly one result beat per command, shown for one cycle with done
// high; fields that do not belong to the command read as zero.
// Entries sit ascending in one dual-port RAM (one write, one registered read).
// When done is high after the accept cycle:
//   clear, unused mode, read past the end: next cycle (busy stays low)
//   read within the list: after the RAM read and the ST_READ state
//   insert rejected: after ST_SCAN checks the last entry; insert at slot s >= 1:
//   after the ST_SCAN walk down to slot s - 1; insert at slot 0: after ST_HEAD.
// An insert walks the RAM from the last entry down, one entry per cycle, moving
// each larger or (above slot 0) equal entry one place along until the new one
// finds its slot; that walk through the single read port sets the insert rate.
// busy is low again in the cycle where done is high, so the next command may
// be accepted then. The receiver cannot stall: done is a strobe.
// Reset (and clear) marks every entry empty through one valid bit per entry,
// so no clearing pass is needed; empty entries read as the maximum energy
// with an all-ones tag. The read pointer returns to zero.
module lowest_n_sorted_insert_list_unit #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned TAG_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          mode,
    input  logic signed [lnsil_pkg::ENERGY_W-1:0] energy,
    input  logic [lnsil_pkg::TAG_PORT_W-1:0]    tag,
    output logic                                done,
    output logic                                inserted,
    output logic [lnsil_pkg::SLOT_W-1:0]        slot,
    output logic signed [lnsil_pkg::ENERGY_W-1:0] read_energy,
    output logic [lnsil_pkg::TAG_PORT_W-1:0]    read_tag,
    output logic                                read_valid
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned PTR_W = $clog2(DEPTH + 1);
    localparam int unsigned ENT_W = lnsil_pkg::ENERGY_W + TAG_WIDTH;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_HEAD = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(DEPTH);

    logic [1:0]               state_reg, state_next;
    lnsil_pkg::energy_t       e_reg, e_next;
    logic [TAG_WIDTH-1:0]     t_reg, t_next;
    logic [IDX_W-1:0]         m_reg, m_next;
    logic [PTR_W-1:0]         ptr_reg, ptr_next;
    logic [DEPTH-1:0]         valid_reg;
    logic                     rd_vld_reg;

    logic                     done_reg, done_next;
    logic                     inserted_reg, inserted_next;
    logic [lnsil_pkg::SLOT_W-1:0] slot_reg, slot_next;
    lnsil_pkg::energy_t       read_energy_reg, read_energy_next;
    logic [lnsil_pkg::TAG_PORT_W-1:0] read_tag_reg, read_tag_next;
    logic                     read_valid_reg, read_valid_next;

    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [ENT_W-1:0]         wr_data;
    logic [ENT_W-1:0]         ram_q;
    logic                     clear_all;

    lnsil_pkg::energy_t       entry_energy;
    logic [TAG_WIDTH-1:0]     entry_tag;
    logic                     move_on;
    logic [IDX_W-1:0]         m_inc;
    logic [IDX_W-1:0]         m_dec;

    lnsil_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // Empty entries read as the maximum energy with an all-ones tag
    assign entry_energy = rd_vld_reg ? $signed(ram_q[ENT_W-1 -: lnsil_pkg::ENERGY_W])
                                     : lnsil_pkg::ENERGY_MAX;
    assign entry_tag    = rd_vld_reg ? ram_q[TAG_WIDTH-1:0] : '1;

    // Entry at m moves one place along when the new energy belongs at or before it
    assign move_on = (m_reg != '0) ? (entry_energy >= e_reg) : (entry_energy > e_reg);
    assign m_inc   = m_reg + IDX_W'(1);
    assign m_dec   = m_reg - IDX_W'(1);

    // Command sequencing
    always_comb
    begin
        state_next       = state_reg;
        e_next           = e_reg;
        t_next           = t_reg;
        m_next           = m_reg;
        ptr_next         = ptr_reg;
        done_next        = 1'b0;
        inserted_next    = 1'b0;
        slot_next        = '0;
        read_energy_next = '0;
        read_tag_next    = '0;
        read_valid_next  = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = '0;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;
        clear_all        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (mode)
                        lnsil_pkg::MODE_INSERT:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = LAST_IDX;
                            m_next     = LAST_IDX;
                            e_next     = energy;
                            t_next     = TAG_WIDTH'(tag);
                            state_next = ST_SCAN;
                        end
                        lnsil_pkg::MODE_READ:
                        begin
                            if (ptr_reg < PTR_END)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = ptr_reg[IDX_W-1:0];
                                state_next = ST_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        lnsil_pkg::MODE_CLEAR:
                        begin
                            clear_all = 1'b1;
                            ptr_next  = '0;
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                done_next        = 1'b1;
                read_valid_next  = 1'b1;
                read_energy_next = entry_energy;
                read_tag_next    = lnsil_pkg::TAG_PORT_W'(entry_tag);
                ptr_next         = ptr_reg + PTR_W'(1);
                state_next       = ST_IDLE;
            end

            ST_SCAN:
            begin
                if (m_reg == LAST_IDX)
                begin
                    // Last entry decides whether the candidate gets in at all
                    if (move_on)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = m_dec;
                        m_next  = m_dec;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (move_on)
                begin
                    // Shift this entry one place along
                    wr_en   = 1'b1;
                    wr_addr = m_inc;
                    wr_data = {entry_energy, entry_tag};
                    if (m_reg == '0)
                    begin
                        state_next = ST_HEAD;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = m_dec;
                        m_next  = m_dec;
                    end
                end
                else
                begin
                    // Drop the candidate into the gap just behind this entry
                    wr_en         = 1'b1;
                    wr_addr       = m_inc;
                    wr_data       = {e_reg, t_reg};
                    done_next     = 1'b1;
                    inserted_next = 1'b1;
                    slot_next     = lnsil_pkg::SLOT_W'(m_inc);
                    state_next    = ST_IDLE;
                end
            end

            ST_HEAD:
            begin
                wr_en         = 1'b1;
                wr_addr       = '0;
                wr_data       = {e_reg, t_reg};
                done_next     = 1'b1;
                inserted_next = 1'b1;
                slot_next     = '0;
                state_next    = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, valid bits and result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ptr_reg         <= '0;
            valid_reg       <= '0;
            rd_vld_reg      <= 1'b0;
            done_reg        <= 1'b0;
            inserted_reg    <= 1'b0;
            slot_reg        <= '0;
            read_energy_reg <= '0;
            read_tag_reg    <= '0;
            read_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ptr_reg         <= ptr_next;
            done_reg        <= done_next;
            inserted_reg    <= inserted_next;
            slot_reg        <= slot_next;
            read_energy_reg <= read_energy_next;
            read_tag_reg    <= read_tag_next;
            read_valid_reg  <= read_valid_next;
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Hold the candidate and the scan index
    always_ff @(posedge clk)
    begin
        e_reg <= e_next;
        t_reg <= t_next;
        m_reg <= m_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign inserted    = inserted_reg;
    assign slot        = slot_reg;
    assign read_energy = read_energy_reg;
    assign read_tag    = read_tag_reg;
    assign read_valid  = read_valid_reg;

endmodule

FILE: design/lnsil_chk.sv
module lnsil_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [1:0]                          mode,
    input logic                                done,
    input logic                                inserted,
    input logic [lnsil_pkg::SLOT_W-1:0]        slot,
    input logic signed [lnsil_pkg::ENERGY_W-1:0] read_energy,
    input logic [lnsil_pkg::TAG_PORT_W-1:0]    read_tag,
    input logic                                read_valid
);

    // Clear answers in the next cycle with an empty beat
    a_clear_beat: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (mode == lnsil_pkg::MODE_CLEAR)
        |=> done && !busy && !inserted && !read_valid && (slot == '0)
            && (read_energy == '0) && (read_tag == '0))
        else $error("clear did not return an empty beat");

    // Insert always needs the scan, so no beat in the next cycle
    a_insert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (mode == lnsil_pkg::MODE_INSERT) |=> busy && !done)
        else $error("insert accepted without a scan");

    // Result fields other than read_tag are quiet outside a beat
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> !inserted && !read_valid && (slot == '0) && (read_energy == '0))
        else $error("result fields active without done");

    // Insert and read fields never share a beat
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done && inserted |-> !read_valid && (read_tag == '0) && (read_energy == '0))
        else $error("insert beat carries read fields");

endmodule

bind lowest_n_sorted_insert_list_unit lnsil_chk u_lnsil_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .done        (done),
    .inserted    (inserted),
    .slot        (slot),
    .read_energy (read_energy),
    .read_tag    (read_tag),
    .read_valid  (read_valid)
);
